[src/ssms_pkg.sv]
// Shared types and constants for the symmetric sparse matrix store.
`default_nettype none

package ssms_pkg;

    // Table and matrix geometry.
    localparam int CAPACITY = 256;
    localparam int MAX_DIM  = 1024;
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int KEY_W    = 2 * IDX_W;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SIZE_W   = 11;
    localparam int VAL_W    = 32;
    localparam int MEM_W    = KEY_W + VAL_W;

    // Command codes.
    localparam logic [1:0] CMD_SET = 2'd0;
    localparam logic [1:0] CMD_GET = 2'd1;
    localparam logic [1:0] CMD_ADD = 2'd2;
    localparam logic [1:0] CMD_SUB = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Saturation bounds.
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]               cmd;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [VAL_W-1:0]  operand;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]  result_value;
        logic [1:0]               status;
        logic [CNT_W-1:0]         entry_count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EXEC = 3'b100
    } t_state;

endpackage

`default_nettype wire

[src/ssms_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ssms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/symmetric_sparse_matrix_store_top.sv]
// Top level of the symmetric sparse matrix store: command sequencer and entry table.
//
//   Channel   Signals                          Transfer condition
//   command   start, busy, i_item              start high and busy low
//   result    o_done, o_result                 o_done high (one cycle, no stall)
//   config    i_cfg_we, i_cfg_wdata            i_cfg_we high
//
// An out-of-range command answers in the cycle after its transfer. Any other
// command scans the entry table, one slot per cycle through the registered
// read port of the RAM, stopping at the first key match or at the last slot.
// The result strobe and the drop of busy come together.
// Reset is synchronous and clears the valid bits and the count at once, as
// does a write of the size register; no clearing pass is needed.
`default_nettype none

module symmetric_sparse_matrix_store_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire ssms_pkg::t_in_item        i_item,
    output logic                           o_done,
    output ssms_pkg::t_out_item            o_result,
    input  wire logic                      i_cfg_we,
    input  wire logic [ssms_pkg::SIZE_W-1:0] i_cfg_wdata
);

    import ssms_pkg::*;

    t_state                  r_state;
    logic [SIZE_W-1:0]       r_size;
    logic [CAPACITY-1:0]     r_valid;
    logic [CNT_W-1:0]        r_count;
    logic [1:0]              r_cmd;
    logic [KEY_W-1:0]        r_key;
    logic signed [VAL_W-1:0] r_operand;
    logic [SLOT_W:0]         r_addr;
    logic                    r_cmp_vld;
    logic [SLOT_W-1:0]       r_cmp_idx;
    logic                    r_hit;
    logic [SLOT_W-1:0]       r_hit_idx;
    logic signed [VAL_W-1:0] r_hit_val;
    logic                    r_free;
    logic [SLOT_W-1:0]       r_free_idx;
    logic                    r_done;
    t_out_item               r_result;

    logic                    w_accept;
    logic                    w_in_range;
    logic [IDX_W-1:0]        w_lo;
    logic [IDX_W-1:0]        w_hi;
    logic                    w_rd_en;
    logic [MEM_W-1:0]        w_rd_data;
    logic [KEY_W-1:0]        w_rd_key;
    logic signed [VAL_W-1:0] w_rd_val;
    logic                    w_match;
    logic                    w_empty;
    logic                    w_last;
    logic                    w_scan_done;
    logic signed [VAL_W-1:0] w_old;
    logic signed [VAL_W:0]   w_sum;
    logic signed [VAL_W-1:0] w_sat;
    logic signed [VAL_W-1:0] w_new_val;
    logic                    w_is_get;
    logic                    w_do_write;
    logic [SLOT_W-1:0]       w_wslot;
    logic [CNT_W-1:0]        n_count;
    t_out_item               n_result;

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // Command transfer, range check and key normalization.
    assign w_accept   = start && !busy;
    assign w_in_range = ({1'b0, i_item.row_index} < r_size) &&
                        ({1'b0, i_item.col_index} < r_size);
    assign w_lo = (i_item.row_index < i_item.col_index) ? i_item.row_index
                                                        : i_item.col_index;
    assign w_hi = (i_item.row_index < i_item.col_index) ? i_item.col_index
                                                        : i_item.row_index;

    // Scan reads one slot per cycle until all slots have been issued.
    assign w_rd_en = (r_state == ST_SCAN) && (r_addr < (SLOT_W + 1)'(CAPACITY));

    ssms_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_do_write && (r_state == ST_EXEC)),
        .i_waddr (w_wslot),
        .i_wdata ({r_key, w_new_val}),
        .i_re    (w_rd_en),
        .i_raddr (r_addr[SLOT_W-1:0]),
        .o_rdata (w_rd_data)
    );

    assign w_rd_key = w_rd_data[MEM_W-1:VAL_W];
    assign w_rd_val = w_rd_data[VAL_W-1:0];

    // Compare stage: the slot read last cycle against the wanted key.
    assign w_match     = r_cmp_vld && r_valid[r_cmp_idx] && (w_rd_key == r_key);
    assign w_empty     = r_cmp_vld && !r_valid[r_cmp_idx];
    assign w_last      = r_cmp_vld && (r_cmp_idx == SLOT_W'(CAPACITY - 1));
    assign w_scan_done = w_match || w_last;

    // Update: pick the slot, compute and saturate the new value.
    always_comb begin
        w_is_get   = (r_cmd == CMD_GET);
        w_old      = r_hit ? r_hit_val : '0;
        w_do_write = !w_is_get && (r_hit || r_free);
        w_wslot    = r_hit ? r_hit_idx : r_free_idx;
        if (r_cmd == CMD_SUB) begin
            w_sum = {w_old[VAL_W-1], w_old} - {r_operand[VAL_W-1], r_operand};
        end else begin
            w_sum = {w_old[VAL_W-1], w_old} + {r_operand[VAL_W-1], r_operand};
        end
        if (w_sum[VAL_W] != w_sum[VAL_W-1]) begin
            w_sat = w_sum[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            w_sat = w_sum[VAL_W-1:0];
        end
        w_new_val = (r_cmd == CMD_SET) ? r_operand : w_sat;
        n_count   = r_count + CNT_W'(w_do_write && !r_hit);

        n_result.entry_count = n_count;
        n_result.status      = (!w_is_get && !r_hit && !r_free) ? STAT_FULL : STAT_OK;
        case (r_cmd)
            CMD_GET: n_result.result_value = w_old;
            CMD_SET: n_result.result_value = w_old;
            default: n_result.result_value = w_do_write ? w_new_val : '0;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_size    <= SIZE_W'(MAX_DIM);
            r_valid   <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_done    <= 1'b0;
            r_cmp_vld <= w_rd_en;
            if (i_cfg_we) begin
                r_size  <= i_cfg_wdata;
                r_valid <= '0;
                r_count <= '0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_in_range) begin
                            r_state <= ST_SCAN;
                            r_addr  <= '0;
                            r_hit   <= 1'b0;
                            r_free  <= 1'b0;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (w_match) begin
                        r_hit <= 1'b1;
                    end
                    if (w_empty && !r_free) begin
                        r_free <= 1'b1;
                    end
                    if (w_scan_done) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_IDLE;
                    r_done  <= 1'b1;
                    r_count <= n_count;
                    if (w_do_write) begin
                        r_valid[w_wslot] <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers: command capture, scan results and the result item.
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr[SLOT_W-1:0];
        if (w_accept) begin
            r_cmd     <= i_item.cmd;
            r_key     <= {w_lo, w_hi};
            r_operand <= i_item.operand;
            if (!w_in_range) begin
                r_result.result_value <= '0;
                r_result.status       <= STAT_RANGE;
                r_result.entry_count  <= r_count;
            end
        end
        if ((r_state == ST_SCAN) && w_match) begin
            r_hit_idx <= r_cmp_idx;
            r_hit_val <= w_rd_val;
        end
        if ((r_state == ST_SCAN) && w_empty && !r_free) begin
            r_free_idx <= r_cmp_idx;
        end
        if (r_state == ST_EXEC) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

[src/ssms_chk.sv]
// Port-level checker for the symmetric sparse matrix store, bound to the top level.
`default_nettype none

module ssms_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire ssms_pkg::t_in_item          i_item,
    input wire logic                        o_done,
    input wire ssms_pkg::t_out_item         o_result,
    input wire logic                        i_cfg_we,
    input wire logic [ssms_pkg::SIZE_W-1:0] i_cfg_wdata
);

    import ssms_pkg::*;

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_done)
        else $error("block not idle after reset");

    // A transferred command either starts a scan or answers at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("command transfer produced neither scan nor result");

    // The end of a scan always delivers its result.
    a_scan_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_done)
        else $error("scan ended without a result");

    // A full-table status is only reported with every slot in use.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status == STAT_FULL) |->
            (o_result.entry_count == CNT_W'(CAPACITY)))
        else $error("table full reported below capacity");

endmodule

bind symmetric_sparse_matrix_store_top ssms_chk u_ssms_chk (.*);

`default_nettype wire

[verif/tb_symmetric_sparse_matrix_store_top.sv]
// Self-checking testbench for the symmetric sparse matrix store top level.
module tb_symmetric_sparse_matrix_store_top;
    import ssms_pkg::*;

    localparam int CLK_PERIOD = 8;

    // Clock, reset and block ports.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_in_item            i_item = '0;
    logic                o_done;
    t_out_item           o_result;
    logic                i_cfg_we = 1'b0;
    logic [SIZE_W-1:0]   i_cfg_wdata = '0;

    // Commands waiting to be driven and replies waiting to arrive.
    t_in_item            cmd_queue[$];
    t_out_item           pending_replies[$];
    logic [KEY_W-1:0]    pair_pool[$];
    bit                  no_idle = 1'b0;
    int                  err_cnt = 0;

    // Shadow copy of the entry table and the size register.
    bit                  tbl_valid[CAPACITY];
    logic [KEY_W-1:0]    tbl_key[CAPACITY];
    logic signed [VAL_W-1:0] tbl_val[CAPACITY];
    int                  tbl_count;
    int                  mat_size;

    symmetric_sparse_matrix_store_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Free-running clock.
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Empties the shadow table, as a reset or a size write does.
    function automatic void clear_table();
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_valid[i] = 1'b0;
        end
        tbl_count = 0;
        pair_pool.delete();
    endfunction

    // Applies one command to the shadow table and returns the reply it should produce.
    function automatic t_out_item apply_command(t_in_item it);
        t_out_item               res;
        int                      lim;
        int                      hit;
        int                      free_slot;
        int                      slot;
        logic [IDX_W-1:0]        lo;
        logic [IDX_W-1:0]        hi;
        logic signed [VAL_W-1:0] old_v;
        logic signed [VAL_W-1:0] new_v;
        logic signed [VAL_W-1:0] opnd;
        longint                  wide;
        res = '0;
        lim = (mat_size < MAX_DIM) ? mat_size : MAX_DIM;
        if (int'(it.row_index) >= lim || int'(it.col_index) >= lim) begin
            res.status = STAT_RANGE;
        end else begin
            lo = (it.row_index < it.col_index) ? it.row_index : it.col_index;
            hi = (it.row_index < it.col_index) ? it.col_index : it.row_index;
            hit = -1;
            free_slot = -1;
            for (int i = 0; i < CAPACITY; i++) begin
                if (tbl_valid[i]) begin
                    if (hit < 0 && tbl_key[i] == {lo, hi}) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (it.cmd == CMD_GET) begin
                res.result_value = (hit >= 0) ? tbl_val[hit] : '0;
            end else begin
                slot = hit;
                old_v = '0;
                if (slot < 0) begin
                    // A missing entry takes the lowest free slot, if there is one.
                    if (free_slot < 0) begin
                        res.status = STAT_FULL;
                    end else begin
                        slot = free_slot;
                        tbl_valid[slot] = 1'b1;
                        tbl_key[slot] = {lo, hi};
                        tbl_val[slot] = '0;
                        tbl_count++;
                    end
                end else begin
                    old_v = tbl_val[slot];
                end
                if (slot >= 0) begin
                    opnd = it.operand;
                    case (it.cmd)
                        CMD_SET: wide = longint'(opnd);
                        CMD_ADD: wide = longint'(old_v) + longint'(opnd);
                        default: wide = longint'(old_v) - longint'(opnd);
                    endcase
                    if (wide > longint'(VAL_MAX)) begin
                        new_v = VAL_MAX;
                    end else if (wide < longint'(VAL_MIN)) begin
                        new_v = VAL_MIN;
                    end else begin
                        new_v = wide[VAL_W-1:0];
                    end
                    tbl_val[slot] = new_v;
                    res.result_value = (it.cmd == CMD_SET) ? old_v : new_v;
                end
            end
        end
        res.entry_count = tbl_count[CNT_W-1:0];
        return res;
    endfunction

    // Builds one directed command.
    function automatic t_in_item cmd_item(logic [1:0] c, int r, int col, logic [VAL_W-1:0] v);
        t_in_item it;
        it.cmd = c;
        it.row_index = r[IDX_W-1:0];
        it.col_index = col[IDX_W-1:0];
        it.operand = v;
        return it;
    endfunction

    // Builds one random command; pairs are often reused, sometimes swapped,
    // so that lookups hit existing entries and the symmetric key is exercised.
    function automatic t_in_item make_item(int idx_hi);
        t_in_item         it;
        int               pick;
        int               small_v;
        logic [KEY_W-1:0] pair;
        pick = $urandom_range(0, 99);
        it.cmd = (pick < 30) ? CMD_SET : (pick < 55) ? CMD_GET : (pick < 80) ? CMD_ADD : CMD_SUB;
        if (pair_pool.size() > 0 && $urandom_range(0, 99) < 40) begin
            pair = pair_pool[$urandom_range(0, pair_pool.size() - 1)];
            if ($urandom_range(0, 1)) pair = {pair[IDX_W-1:0], pair[KEY_W-1:IDX_W]};
        end else begin
            pair = {IDX_W'($urandom_range(0, idx_hi)), IDX_W'($urandom_range(0, idx_hi))};
            pair_pool.push_back(pair);
            if (pair_pool.size() > 64) pair_pool.delete(0);
        end
        {it.row_index, it.col_index} = pair;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            case ($urandom_range(0, 3))
                0: it.operand = VAL_MAX;
                1: it.operand = VAL_MIN;
                2: it.operand = '0;
                default: it.operand = '1;
            endcase
        end else if (pick < 45) begin
            small_v = $urandom_range(0, 131072);
            it.operand = small_v - 65536;
        end else begin
            it.operand = $urandom;
        end
        return it;
    endfunction

    task automatic queue_random(int n, int idx_hi);
        for (int k = 0; k < n; k++) begin
            cmd_queue.push_back(make_item(idx_hi));
        end
    endtask

    // Waits until every command has been transferred and every reply checked.
    // The check runs at the falling edge, once the driver's updates have settled.
    task automatic drain();
        while (cmd_queue.size() > 0 || start || pending_replies.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the size register while the block is idle; the write clears the store.
    task automatic write_matrix_size(logic [SIZE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mat_size = v;
        clear_table();
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    // Command driver: predicts each transfer and presents the next command,
    // idling at random unless a no-idle stretch is running.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                pending_replies.push_back(apply_command(i_item));
            end
            if (!start || !busy) begin
                if (cmd_queue.size() > 0 && (no_idle || $urandom_range(0, 99) >= 22)) begin
                    start <= 1'b1;
                    i_item <= cmd_queue.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: each strobed reply is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("reply with no command outstanding");
            end else begin
                want = pending_replies.pop_front();
                if (o_result.result_value !== want.result_value) begin
                    report_mismatch($sformatf("result_value got %h expected %h",
                                              o_result.result_value, want.result_value));
                end
                if (o_result.status !== want.status) begin
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              o_result.status, want.status));
                end
                if (o_result.entry_count !== want.entry_count) begin
                    report_mismatch($sformatf("entry_count got %0d expected %0d",
                                              o_result.entry_count, want.entry_count));
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        mat_size = 1024;
        clear_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed commands at reset size: saturation, symmetry, absent entries
        // and index extremes.
        cmd_queue.push_back(cmd_item(CMD_GET, 0, 0, 32'h0000_0000));
        cmd_queue.push_back(cmd_item(CMD_SET, 0, 0, VAL_MAX));
        cmd_queue.push_back(cmd_item(CMD_ADD, 0, 0, 32'h0000_0001));
        cmd_queue.push_back(cmd_item(CMD_SET, 0, 0, VAL_MIN));
        cmd_queue.push_back(cmd_item(CMD_SUB, 0, 0, 32'h0000_0001));
        cmd_queue.push_back(cmd_item(CMD_GET, 0, 0, 32'h0000_0000));
        cmd_queue.push_back(cmd_item(CMD_SET, 3, 5, 32'h0001_8000));
        cmd_queue.push_back(cmd_item(CMD_GET, 5, 3, 32'h0000_0000));
        cmd_queue.push_back(cmd_item(CMD_ADD, 5, 3, 32'hFFFF_FFFF));
        cmd_queue.push_back(cmd_item(CMD_SUB, 1023, 0, VAL_MIN));
        cmd_queue.push_back(cmd_item(CMD_GET, 0, 1023, 32'h0000_0000));
        cmd_queue.push_back(cmd_item(CMD_ADD, 1023, 1023, VAL_MIN));
        cmd_queue.push_back(cmd_item(CMD_SUB, 1023, 1023, VAL_MAX));
        cmd_queue.push_back(cmd_item(CMD_SET, 512, 256, 32'h0000_0000));
        cmd_queue.push_back(cmd_item(CMD_GET, 256, 512, 32'h0000_0000));
        cmd_queue.push_back(cmd_item(CMD_ADD, 682, 341, 32'h7FFF_0000));
        cmd_queue.push_back(cmd_item(CMD_SET, 341, 682, 32'h5555_5555));
        cmd_queue.push_back(cmd_item(CMD_SUB, 0, 1, 32'h1234_5678));
        cmd_queue.push_back(cmd_item(CMD_SET, 0, 1, 32'h0000_0000));
        cmd_queue.push_back(cmd_item(CMD_GET, 1, 2, 32'h0000_0000));
        drain();

        // A small matrix: indices past the edge are rejected and the table fills up.
        write_matrix_size(11'd23);
        cmd_queue.push_back(cmd_item(CMD_SET, 23, 0, 32'h0000_0001));
        cmd_queue.push_back(cmd_item(CMD_GET, 0, 23, 32'h0000_0000));
        cmd_queue.push_back(cmd_item(CMD_ADD, 1023, 1023, 32'h0000_0001));
        cmd_queue.push_back(cmd_item(CMD_SET, 22, 22, 32'hDEAD_BEEF));
        queue_random(480, 25);
        drain();

        // One-element matrix, then a size of zero where every index is out of range.
        no_idle = 1'b1;
        write_matrix_size(11'd1);
        queue_random(40, 1);
        drain();
        write_matrix_size(11'd0);
        queue_random(12, 3);
        drain();
        no_idle = 1'b0;

        // Largest register value: behaves as the full dimension; fills the table.
        write_matrix_size(11'd2047);
        queue_random(620, 1023);
        drain();

        // Back to the full dimension, first without idling, then with it.
        write_matrix_size(11'd1024);
        no_idle = 1'b1;
        queue_random(200, 1023);
        drain();
        no_idle = 1'b0;
        queue_random(280, 1023);
        drain();

        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("symmetric_sparse_matrix_store_top test passed");
        end else begin
            $display("symmetric_sparse_matrix_store_top test failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #(CLK_PERIOD * 2_500_000);
        $display("symmetric_sparse_matrix_store_top test failed");
        $finish;
    end

endmodule

[files.f]
src/ssms_pkg.sv
src/ssms_ram.sv
src/symmetric_sparse_matrix_store_top.sv
src/ssms_chk.sv
verif/tb_symmetric_sparse_matrix_store_top.sv
